/* rtl/core/sh256_pkg.sv */
// Shared types, constants and helper functions of the SHA-256 stream hasher.
package sh256_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LOAD,
		S_ROUND,
		S_FOLD,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_MARK,
		PH_BODY,
		PH_DONE
	} phase_t;

	// Working variables a..h, index 0 is a.
	typedef logic [7:0][31:0] vars_t;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [5:0] LAST_BYTE = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [1:0] LAST_WORD_IDX = 2'd3;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

/* rtl/core/sh256_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sh256_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/sh256_round.sv */
// One SHA-256 compression round: next working variables from the current ones.
module sh256_round import sh256_pkg::*; (
	input  vars_t       vars,
	input  logic [31:0] w,
	input  logic [31:0] k,
	output vars_t       vars_next
);

	logic [31:0] ch;
	logic [31:0] mj;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		ch = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
		mj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
		t1 = vars[7] + big_sigma1(vars[4]) + ch + k + w;
		t2 = big_sigma0(vars[0]) + mj;
		vars_next[7] = vars[6];
		vars_next[6] = vars[5];
		vars_next[5] = vars[4];
		vars_next[4] = vars[3] + t1;
		vars_next[3] = vars[2];
		vars_next[2] = vars[1];
		vars_next[1] = vars[0];
		vars_next[0] = t1 + t2;
	end

endmodule

/* rtl/core/sha256_stream_hasher.sv */
// SHA-256 stream hasher: byte absorb, padding sequencer, round unit and digest output.
//
// Input channel (in_valid/in_stall, mode, data_byte): mode 0 absorbs one message
// byte, mode 1 finishes the message. Output channel (out_valid/out_stall) carries
// the digest as four 64-bit words, word_index 0 first, last_word set on index 3.
// A transfer happens on a rising edge with valid high and stall low.
// Bytes are absorbed at one per cycle while in_stall is low; the byte that
// completes a 64-byte block starts a compression (a load, 64 rounds through
// the single shared round unit, a chaining fold), during which in_stall is high.
// A finish pushes the padding one byte per cycle through the same byte path:
// 9 to 72 pad bytes with one or two block compressions, then hands out the four digest
// words; the block then restarts with the initial hash values and an empty message.
// Block bytes are packed into a 16 x 32 RAM; the message schedule is a 16-word
// shift line fed by the RAM for the first 16 rounds.
// Reset returns the initial hash values, an empty buffer and no pending output.
// A stalled receiver holds the current digest word; each word is loaded only once the
// word before it is taken, and input stays stalled until the last word is loaded.
module sha256_stream_hasher import sh256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	state_t      state_q;
	state_t      state_next;
	phase_t      phase_q;
	logic        pad_wrap_q;
	logic [31:0] chain_q [8];
	vars_t       vars_q;
	vars_t       vars_next;
	logic [31:0] sched_q [16];
	logic [5:0]  count_q;
	logic [63:0] bits_q;
	logic [63:0] len_sh_q;
	logic [23:0] acc_q;
	logic [5:0]  round_q;
	logic [1:0]  out_idx_q;
	logic        out_valid_q;
	logic [63:0] digest_q;
	logic [1:0]  word_idx_q;
	logic        last_q;

	logic        accept;
	logic        push_en;
	logic [7:0]  push_data;
	logic        block_full;
	logic        load_out;
	logic        rd_en;
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;
	logic [31:0] w_new;
	logic [31:0] w_cur;

	assign accept     = in_valid && !in_stall;
	assign block_full = push_en && (count_q == LAST_BYTE);
	assign w_new      = sched_q[0] + small_sigma0(sched_q[1]) + sched_q[9]
		+ small_sigma1(sched_q[14]);
	assign w_cur      = (round_q[5:4] == 2'b00) ? rd_data : w_new;

	sh256_ram #(
		.WIDTH(32),
		.DEPTH(16)
	) u_block_ram (
		.clk     (clk),
		.wr_en   (push_en && (count_q[1:0] == 2'b11)),
		.wr_addr (count_q[5:2]),
		.wr_data ({acc_q, push_data}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sh256_round u_round (
		.vars      (vars_q),
		.w         (w_cur),
		.k         (ROUND_K[round_q]),
		.vars_next (vars_next)
	);

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode) begin
						state_next = S_PAD;
					end else if (block_full) begin
						state_next = S_LOAD;
					end
				end
			end
			S_PAD: begin
				if (block_full) begin
					state_next = S_LOAD;
				end
			end
			S_LOAD: begin
				state_next = S_ROUND;
			end
			S_ROUND: begin
				if (round_q == LAST_ROUND) begin
					state_next = S_FOLD;
				end
			end
			S_FOLD: begin
				unique case (phase_q)
					PH_NONE:          state_next = S_IDLE;
					PH_MARK, PH_BODY: state_next = S_PAD;
					PH_DONE:          state_next = S_OUT;
				endcase
			end
			S_OUT: begin
				if (load_out && (out_idx_q == LAST_WORD_IDX)) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		push_en   = 1'b0;
		push_data = data_byte;
		load_out  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = 4'd0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				push_en  = in_valid && !mode;
			end
			S_PAD: begin
				push_en = 1'b1;
				if (phase_q == PH_MARK) begin
					push_data = PAD_MARK;
				end else if (count_q >= LEN_START && !pad_wrap_q) begin
					push_data = len_sh_q[63:56];
				end else begin
					push_data = 8'd0;
				end
			end
			S_LOAD: begin
				rd_en = 1'b1;
			end
			S_ROUND: begin
				rd_en   = 1'b1;
				rd_addr = round_q[3:0] + 4'd1;
			end
			S_FOLD: begin
			end
			S_OUT: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_NONE;
			pad_wrap_q  <= 1'b0;
			count_q     <= '0;
			bits_q      <= '0;
			round_q     <= '0;
			out_idx_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else begin
			state_q <= state_next;

			if (push_en) begin
				count_q <= count_q + 6'd1;
			end

			if (accept) begin
				if (mode) begin
					phase_q <= PH_MARK;
				end else begin
					bits_q <= bits_q + 64'd8;
				end
			end

			// Advance the padding phase as pad bytes go in
			if (state_q == S_PAD) begin
				if (phase_q == PH_MARK) begin
					phase_q <= PH_BODY;
				end else if (count_q == LAST_BYTE && phase_q == PH_BODY && !pad_wrap_q) begin
					phase_q <= PH_DONE;
				end
			end

			// Zero-fill to the end of the block when the marker lands in the length field
			if (state_q == S_PAD) begin
				if (block_full) begin
					pad_wrap_q <= 1'b0;
				end else if (phase_q == PH_MARK && count_q >= LEN_START) begin
					pad_wrap_q <= 1'b1;
				end
			end

			if (state_q == S_ROUND) begin
				round_q <= round_q + 6'd1;
			end

			if (state_q == S_FOLD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + vars_q[i];
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= out_idx_q + 2'd1;
				if (out_idx_q == LAST_WORD_IDX) begin
					// Restart for the next message
					phase_q <= PH_NONE;
					bits_q  <= '0;
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= INIT_H[i];
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, no reset
	always_ff @(posedge clk) begin
		if (push_en) begin
			acc_q <= {acc_q[15:0], push_data};
		end
		if (accept && mode) begin
			len_sh_q <= bits_q;
		end else if (state_q == S_PAD && phase_q == PH_BODY && count_q >= LEN_START
				&& !pad_wrap_q) begin
			len_sh_q <= {len_sh_q[55:0], 8'd0};
		end
		if (state_q == S_LOAD) begin
			for (int i = 0; i < 8; i++) begin
				vars_q[i] <= chain_q[i];
			end
		end else if (state_q == S_ROUND) begin
			vars_q <= vars_next;
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= w_cur;
		end
		if (load_out) begin
			digest_q   <= {chain_q[{out_idx_q, 1'b0}], chain_q[{out_idx_q, 1'b1}]};
			word_idx_q <= out_idx_q;
			last_q     <= (out_idx_q == LAST_WORD_IDX);
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = word_idx_q;
	assign last_word   = last_q;

`ifndef SYNTHESIS
	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ROUND) |-> (round_q == 6'd0))
		else $error("round counter not at zero outside the rounds");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && round_q == LAST_ROUND) |=> (state_q == S_FOLD))
		else $error("compression did not fold after the final round");

	a_out_empty_buf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (count_q == 6'd0 && phase_q == PH_DONE))
		else $error("digest output with a partly filled block");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_word) |-> (word_index == LAST_WORD_IDX))
		else $error("last word flag on a word other than the final one");
`endif

endmodule
